// ----- src/h2r_pkg.sv -----
package h2r_pkg;

    localparam logic [10:0] HUE_SCALE = 11'd6;
    localparam logic [8:0]  TRI_HALF  = 9'd256;

    localparam logic [2:0] SECTOR_RED_YEL = 3'd0;
    localparam logic [2:0] SECTOR_YEL_GRN = 3'd1;
    localparam logic [2:0] SECTOR_GRN_CYN = 3'd2;
    localparam logic [2:0] SECTOR_CYN_BLU = 3'd3;
    localparam logic [2:0] SECTOR_BLU_MAG = 3'd4;
    localparam logic [2:0] SECTOR_MAG_RED = 3'd5;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] chroma;
        logic [8:0] factor;
        logic [2:0] sector;
        logic       zero;
    } t_chroma;

    typedef struct packed {
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
        logic [2:0] sector;
        logic       zero;
    } t_mix;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

// ----- src/h2r_hsv_if.sv -----
interface h2r_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ----- src/h2r_rgb_if.sv -----
interface h2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/h2r_stage_chroma.sv -----
module h2r_stage_chroma (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  h2r_pkg::t_hsv    i_data,
    output logic             o_ready,
    output logic             o_valid,
    output h2r_pkg::t_chroma o_data,
    input  logic             i_ready
);
    import h2r_pkg::*;

    logic        r_valid;
    t_chroma     r_data;
    t_chroma     n_data;
    logic [15:0] w_sv;
    logic [10:0] w_hp;
    logic [8:0]  w_pos;

    always_comb begin
        w_sv  = 16'(i_data.saturation) * 16'(i_data.brightness);
        w_hp  = 11'(i_data.hue) * HUE_SCALE;
        w_pos = w_hp[8:0];
        n_data.brightness = i_data.brightness;
        n_data.chroma     = w_sv[15:8];
        // triangle peaks at the boundary between an even sector and the odd sector after it
        n_data.factor     = w_pos[8] ? (TRI_HALF - 9'(w_pos[7:0])) : w_pos;
        n_data.sector     = w_hp[10:8];
        n_data.zero       = (i_data.brightness == 8'd0);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_chroma_le_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_data.chroma <= r_data.brightness)
        else $error("chroma above value");

    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_data.factor <= TRI_HALF)
        else $error("triangle factor out of range");
endmodule

// ----- src/h2r_stage_mix.sv -----
module h2r_stage_mix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  h2r_pkg::t_chroma i_data,
    output logic             o_ready,
    output logic             o_valid,
    output h2r_pkg::t_mix    o_data,
    input  logic             i_ready
);
    import h2r_pkg::*;

    logic        r_valid;
    t_mix        r_data;
    t_mix        n_data;
    logic [16:0] w_cx;
    logic [7:0]  w_lo;

    always_comb begin
        w_cx = 17'(i_data.chroma) * 17'(i_data.factor);
        w_lo = i_data.brightness - i_data.chroma;
        n_data.hi     = i_data.brightness;
        // x never exceeds chroma, so the top product bit stays clear
        n_data.mid    = w_cx[15:8] + w_lo;
        n_data.lo     = w_lo;
        n_data.sector = i_data.sector;
        n_data.zero   = i_data.zero;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    a_mid_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.mid <= r_data.hi) && (r_data.lo <= r_data.mid))
        else $error("mid level outside lo..hi");
endmodule

// ----- src/h2r_stage_route.sv -----
module h2r_stage_route (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  h2r_pkg::t_mix i_data,
    output logic          o_ready,
    output logic          o_valid,
    output h2r_pkg::t_rgb o_data,
    input  logic          i_ready
);
    import h2r_pkg::*;

    logic r_valid;
    t_rgb r_data;
    t_rgb n_data;

    always_comb begin
        n_data = '0;
        if (!i_data.zero) begin
            unique case (i_data.sector)
                SECTOR_RED_YEL: n_data = '{i_data.hi,  i_data.mid, i_data.lo};
                SECTOR_YEL_GRN: n_data = '{i_data.mid, i_data.hi,  i_data.lo};
                SECTOR_GRN_CYN: n_data = '{i_data.lo,  i_data.hi,  i_data.mid};
                SECTOR_CYN_BLU: n_data = '{i_data.lo,  i_data.mid, i_data.hi};
                SECTOR_BLU_MAG: n_data = '{i_data.mid, i_data.lo,  i_data.hi};
                SECTOR_MAG_RED: n_data = '{i_data.hi,  i_data.lo,  i_data.mid};
                default:        n_data = '0;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

// ----- src/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, 8 bits per component. One request enters per clock while the output
// side is ready and passes through registered stages to the output channel: a chroma and hue-scale stage
// (8x8 and 8x3 multiply), a mix stage (8x9 multiply for the intermediate level) and a
// routing stage that doubles as the output register. Throughput is one pixel per clock
// whenever the output side is ready; each stage holds its request under backpressure, so
// up to three requests are in flight. Zero brightness always gives black. No configuration.
module hsv_to_rgb_converter (
    input logic i_clk,
    input logic i_rst_n,
    h2r_hsv_if.sink   i_hsv,
    h2r_rgb_if.source o_rgb
);
    import h2r_pkg::*;

    t_hsv    w_in;
    t_chroma w_s1_data;
    t_mix    w_s2_data;
    t_rgb    w_out;
    logic    w_s1_valid;
    logic    w_s1_ready;
    logic    w_s2_valid;
    logic    w_s2_ready;
    logic    w_s3_ready;

    assign w_in = '{i_hsv.hue, i_hsv.saturation, i_hsv.brightness};

    h2r_stage_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_hsv.valid),
        .i_data  (w_in),
        .o_ready (i_hsv.ready),
        .o_valid (w_s1_valid),
        .o_data  (w_s1_data),
        .i_ready (w_s1_ready)
    );

    h2r_stage_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_data),
        .o_ready (w_s1_ready),
        .o_valid (w_s2_valid),
        .o_data  (w_s2_data),
        .i_ready (w_s2_ready)
    );

    h2r_stage_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .i_data  (w_s2_data),
        .o_ready (w_s2_ready),
        .o_valid (o_rgb.valid),
        .o_data  (w_out),
        .i_ready (w_s3_ready)
    );

    assign w_s3_ready  = o_rgb.ready;
    assign o_rgb.red   = w_out.red;
    assign o_rgb.green = w_out.green;
    assign o_rgb.blue  = w_out.blue;

    // a request parked in the mix stage must not move or change while routing is stalled
    a_mix_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && !w_s2_ready) |=> w_s2_valid && $stable(w_s2_data))
        else $error("mix stage lost a stalled request");

    a_chroma_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_valid && !w_s1_ready) |=> w_s1_valid && $stable(w_s1_data))
        else $error("chroma stage lost a stalled request");
endmodule
